@@ hw/rtl/doubly_linked_list_manager_macros.svh @@
// Assertion macros for the list manager
`ifndef DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH
`define DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH

// Checked only while out of reset
`define DLLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define DLLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dllm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

    localparam int NODE_W = 8;
    localparam int PTR_W  = 9;
    localparam int CNT_W  = 9;
    localparam int LIST_W = 2;
    localparam int LISTS  = 4;
    localparam int NODES  = 256;

    localparam logic [PTR_W-1:0] PTR_NONE = 9'd256;
    localparam logic [CNT_W-1:0] CNT_MAX  = 9'd511;

    localparam logic [3:0] OP_CLEAR        = 4'd0;
    localparam logic [3:0] OP_INS_HEAD     = 4'd1;
    localparam logic [3:0] OP_INS_TAIL     = 4'd2;
    localparam logic [3:0] OP_INS_AFTER    = 4'd3;
    localparam logic [3:0] OP_INS_BEFORE   = 4'd4;
    localparam logic [3:0] OP_POP_HEAD     = 4'd5;
    localparam logic [3:0] OP_POP_TAIL     = 4'd6;
    localparam logic [3:0] OP_REMOVE       = 4'd7;
    localparam logic [3:0] OP_SPLICE_FRONT = 4'd8;
    localparam logic [3:0] OP_SPLICE_BACK  = 4'd9;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_LIMIT = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]        op;
        logic [LIST_W-1:0] list_id;
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] ref_node;
        logic [LIST_W-1:0] src_list;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] popped_node;
        logic [CNT_W-1:0]  list_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WR1,
        S_WR2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic wr1;
        logic wr2;
        logic rsp_load;
    } t_cmd;

    typedef struct packed {
        logic need_read;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/dllm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dllm_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [dllm_pkg::CNT_W-1:0] i_cfg_data,
    input  wire dllm_pkg::t_req            i_req,
    input  wire dllm_pkg::t_cmd            i_cmd,
    output dllm_pkg::t_stat                o_stat,
    output dllm_pkg::t_rsp                 o_rsp
);

    localparam int PW = dllm_pkg::PTR_W;
    localparam int CW = dllm_pkg::CNT_W;
    localparam logic [PW-1:0] NONE = dllm_pkg::PTR_NONE;

    dllm_pkg::t_req r_req;
    dllm_pkg::t_rsp r_res;
    dllm_pkg::t_rsp r_rsp;
    logic [CW-1:0]  r_max;
    logic [PW-1:0]  r_head [dllm_pkg::LISTS];
    logic [PW-1:0]  r_tail [dllm_pkg::LISTS];
    logic [CW-1:0]  r_cnt  [dllm_pkg::LISTS];
    logic [PW-1:0]  mem_next [dllm_pkg::NODES];
    logic [PW-1:0]  mem_prev [dllm_pkg::NODES];
    logic [PW-1:0]  r_rd_next;
    logic [PW-1:0]  r_rd_prev;

    logic [PW-1:0] h, t, hs, ts, pn, pr, rd_a;
    logic [CW-1:0] c, cs;
    logic [CW:0]   sum;
    logic          full;
    logic [1:0]    sts;
    logic [dllm_pkg::NODE_W-1:0] popped;
    logic [PW-1:0] nh, nt;
    logic [CW-1:0] nc;
    logic          clr_s;
    logic          w1n_en, w1p_en, w2n_en, w2p_en;
    logic [PW-1:0] w1n_a, w1n_d, w1p_a, w1p_d, w2n_a, w2n_d, w2p_a, w2p_d;
    logic          wn_en, wp_en;
    logic [PW-1:0] wn_a, wn_d, wp_a, wp_d;

    always_comb begin
        h    = r_head[r_req.list_id];
        t    = r_tail[r_req.list_id];
        c    = r_cnt[r_req.list_id];
        hs   = r_head[r_req.src_list];
        ts   = r_tail[r_req.src_list];
        cs   = r_cnt[r_req.src_list];
        pn   = {1'b0, r_req.node_id};
        pr   = {1'b0, r_req.ref_node};
        sum  = {1'b0, c} + {1'b0, cs};
        full = (c == dllm_pkg::CNT_MAX) || ((r_max != '0) && (c >= r_max));
        sts    = dllm_pkg::STS_OK;
        popped = '0;
        nh     = h;
        nt     = t;
        nc     = c;
        clr_s  = 1'b0;
        rd_a   = NONE;
        w1n_en = 1'b0; w1n_a = NONE; w1n_d = NONE;
        w1p_en = 1'b0; w1p_a = NONE; w1p_d = NONE;
        w2n_en = 1'b0; w2n_a = NONE; w2n_d = NONE;
        w2p_en = 1'b0; w2p_a = NONE; w2p_d = NONE;
        case (r_req.op)
            dllm_pkg::OP_CLEAR: begin
                nh = NONE;
                nt = NONE;
                nc = '0;
            end
            dllm_pkg::OP_INS_HEAD: begin
                if (full) begin
                    sts = dllm_pkg::STS_LIMIT;
                end else begin
                    w1n_en = 1'b1; w1n_a = pn; w1n_d = h;
                    w1p_en = !h[PW-1]; w1p_a = h; w1p_d = pn;
                    w2p_en = 1'b1; w2p_a = pn; w2p_d = NONE;
                    nh = pn;
                    if (h[PW-1]) nt = pn;
                    nc = c + 1'b1;
                end
            end
            dllm_pkg::OP_INS_TAIL: begin
                if (full) begin
                    sts = dllm_pkg::STS_LIMIT;
                end else begin
                    w1p_en = 1'b1; w1p_a = pn; w1p_d = t;
                    w1n_en = !t[PW-1]; w1n_a = t; w1n_d = pn;
                    w2n_en = 1'b1; w2n_a = pn; w2n_d = NONE;
                    nt = pn;
                    if (t[PW-1]) nh = pn;
                    nc = c + 1'b1;
                end
            end
            dllm_pkg::OP_INS_AFTER: begin
                rd_a = pr;
                if (full) begin
                    sts = dllm_pkg::STS_LIMIT;
                end else begin
                    w1n_en = 1'b1; w1n_a = pr; w1n_d = pn;
                    w1p_en = 1'b1; w1p_a = pn; w1p_d = pr;
                    w2n_en = 1'b1; w2n_a = pn; w2n_d = r_rd_next;
                    w2p_en = !r_rd_next[PW-1]; w2p_a = r_rd_next; w2p_d = pn;
                    if (r_rd_next[PW-1]) nt = pn;
                    nc = c + 1'b1;
                end
            end
            dllm_pkg::OP_INS_BEFORE: begin
                rd_a = pr;
                if (full) begin
                    sts = dllm_pkg::STS_LIMIT;
                end else begin
                    w1p_en = 1'b1; w1p_a = pr; w1p_d = pn;
                    w1n_en = 1'b1; w1n_a = pn; w1n_d = pr;
                    w2p_en = 1'b1; w2p_a = pn; w2p_d = r_rd_prev;
                    w2n_en = !r_rd_prev[PW-1]; w2n_a = r_rd_prev; w2n_d = pn;
                    if (r_rd_prev[PW-1]) nh = pn;
                    nc = c + 1'b1;
                end
            end
            dllm_pkg::OP_POP_HEAD: begin
                rd_a = h;
                if (c == '0) begin
                    sts = dllm_pkg::STS_EMPTY;
                end else begin
                    if (r_rd_next[PW-1]) begin
                        nh = NONE;
                        nt = NONE;
                    end else begin
                        nh = r_rd_next;
                        w1p_en = 1'b1; w1p_a = r_rd_next; w1p_d = NONE;
                    end
                    w1n_en = 1'b1; w1n_a = h; w1n_d = NONE;
                    popped = h[PW-1] ? '0 : h[PW-2:0];
                    nc = c - 1'b1;
                end
            end
            dllm_pkg::OP_POP_TAIL: begin
                rd_a = t;
                if (c == '0) begin
                    sts = dllm_pkg::STS_EMPTY;
                end else begin
                    if (r_rd_prev[PW-1]) begin
                        nh = NONE;
                        nt = NONE;
                    end else begin
                        nt = r_rd_prev;
                        w1n_en = 1'b1; w1n_a = r_rd_prev; w1n_d = NONE;
                    end
                    w1p_en = 1'b1; w1p_a = t; w1p_d = NONE;
                    popped = t[PW-1] ? '0 : t[PW-2:0];
                    nc = c - 1'b1;
                end
            end
            dllm_pkg::OP_REMOVE: begin
                rd_a = pn;
                if (c == '0) begin
                    sts = dllm_pkg::STS_EMPTY;
                end else begin
                    w1p_en = 1'b1; w1p_a = r_rd_next; w1p_d = r_rd_prev;
                    w1n_en = 1'b1; w1n_a = r_rd_prev; w1n_d = r_rd_next;
                    w2p_en = 1'b1; w2p_a = pn; w2p_d = NONE;
                    w2n_en = 1'b1; w2n_a = pn; w2n_d = NONE;
                    if (r_rd_prev[PW-1]) nh = r_rd_next;
                    if (r_rd_next[PW-1]) nt = r_rd_prev;
                    nc = c - 1'b1;
                end
            end
            dllm_pkg::OP_SPLICE_FRONT, dllm_pkg::OP_SPLICE_BACK: begin
                if (r_req.src_list != r_req.list_id) begin
                    if ((sum > {1'b0, dllm_pkg::CNT_MAX})
                        || ((r_max != '0) && (sum > {1'b0, r_max}))) begin
                        sts = dllm_pkg::STS_LIMIT;
                    end else if (cs != '0) begin
                        if (c == '0) begin
                            nh = hs;
                            nt = ts;
                        end else if (r_req.op == dllm_pkg::OP_SPLICE_FRONT) begin
                            w1p_en = 1'b1; w1p_a = h; w1p_d = ts;
                            w1n_en = 1'b1; w1n_a = ts; w1n_d = h;
                            nh = hs;
                        end else begin
                            w1n_en = 1'b1; w1n_a = t; w1n_d = hs;
                            w1p_en = 1'b1; w1p_a = hs; w1p_d = t;
                            nt = ts;
                        end
                        nc = sum[CW-1:0];
                        clr_s = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        wn_en = i_cmd.wr2 ? w2n_en : (i_cmd.wr1 && w1n_en);
        wn_a  = i_cmd.wr2 ? w2n_a : w1n_a;
        wn_d  = i_cmd.wr2 ? w2n_d : w1n_d;
        wp_en = i_cmd.wr2 ? w2p_en : (i_cmd.wr1 && w1p_en);
        wp_a  = i_cmd.wr2 ? w2p_a : w1p_a;
        wp_d  = i_cmd.wr2 ? w2p_d : w1p_d;
    end

    assign o_stat.need_read = (i_req.op >= dllm_pkg::OP_INS_AFTER)
                           && (i_req.op <= dllm_pkg::OP_REMOVE);
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_next <= rd_a[PW-1] ? NONE : mem_next[rd_a[PW-2:0]];
            r_rd_prev <= rd_a[PW-1] ? NONE : mem_prev[rd_a[PW-2:0]];
        end
        if (wn_en && !wn_a[PW-1]) begin
            mem_next[wn_a[PW-2:0]] <= wn_d;
        end
        if (wp_en && !wp_a[PW-1]) begin
            mem_prev[wp_a[PW-2:0]] <= wp_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.wr2) begin
            r_res.status      <= sts;
            r_res.popped_node <= popped;
            r_res.list_count  <= nc;
        end
        if (i_cmd.rsp_load) begin
            r_rsp <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            for (int i = 0; i < dllm_pkg::LISTS; i++) begin
                r_head[i] <= NONE;
                r_tail[i] <= NONE;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.wr2) begin
                if (clr_s) begin
                    r_head[r_req.src_list] <= NONE;
                    r_tail[r_req.src_list] <= NONE;
                    r_cnt[r_req.src_list]  <= '0;
                end
                r_head[r_req.list_id] <= nh;
                r_tail[r_req.list_id] <= nt;
                r_cnt[r_req.list_id]  <= nc;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dllm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "doubly_linked_list_manager_macros.svh"

module dllm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    input  wire dllm_pkg::t_stat i_stat,
    output dllm_pkg::t_cmd       o_cmd
);

    dllm_pkg::t_state r_state;
    dllm_pkg::t_state n_state;
    logic             r_rsp_valid;
    logic             n_rsp_valid;
    logic             rsp_free;

    assign rsp_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dllm_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_stat.need_read ? dllm_pkg::S_READ : dllm_pkg::S_WR1;
                end
            end
            dllm_pkg::S_READ: n_state = dllm_pkg::S_WR1;
            dllm_pkg::S_WR1:  n_state = dllm_pkg::S_WR2;
            dllm_pkg::S_WR2:  n_state = dllm_pkg::S_RESP;
            dllm_pkg::S_RESP: begin
                if (rsp_free) n_state = dllm_pkg::S_IDLE;
            end
            default: n_state = dllm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            dllm_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            dllm_pkg::S_READ: o_cmd.rd  = 1'b1;
            dllm_pkg::S_WR1:  o_cmd.wr1 = 1'b1;
            dllm_pkg::S_WR2:  o_cmd.wr2 = 1'b1;
            dllm_pkg::S_RESP: o_cmd.rsp_load = rsp_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.rsp_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dllm_pkg::S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    `DLLM_ASSERT(a_accept_path, i_clk, i_rst_n, i_req_valid && o_req_ready |=> (r_state == dllm_pkg::S_READ || r_state == dllm_pkg::S_WR1), "request did not start work")
    `DLLM_ASSERT(a_read_then_write, i_clk, i_rst_n, r_state == dllm_pkg::S_READ |=> r_state == dllm_pkg::S_WR1, "read not followed by write")
    `DLLM_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.rsp_load |-> (!r_rsp_valid || i_rsp_ready), "pending result overwritten")
    `DLLM_ASSERT_ALWAYS(a_one_phase, i_clk, $onehot0({o_cmd.load, o_cmd.rd, o_cmd.wr1, o_cmd.wr2, o_cmd.rsp_load}), "overlapping commands")

endmodule

`default_nettype wire

@@ hw/rtl/doubly_linked_list_manager.sv @@
// Doubly linked list manager: four lists over a pool of 256 nodes.
// Request channel (i_req_valid / o_req_ready / i_req) carries one
// operation; response channel (o_rsp_valid / i_rsp_ready / o_rsp) returns
// exactly one result per request, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// per-list limit; it is always ready. Write it only while idle.
// After acceptance, operations that read a link (insert after/before, pops,
// remove) pass a read state before the two write states; the rest do not.
// No new request is taken until the current one is done, as the single-port
// next and previous link memories need the read and both write states.
// A result waiting in the output register does not block acceptance of
// the next request; if the receiver stalls, the next result holds inside
// until the output register frees, and no new request is taken meanwhile.
// Reset (synchronous, active low) empties all lists and clears the limit;
// link memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire dllm_pkg::t_req             i_req,
    output logic                            o_rsp_valid,
    input  wire logic                       i_rsp_ready,
    output dllm_pkg::t_rsp                  o_rsp,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [dllm_pkg::CNT_W-1:0] i_cfg_data
);

    dllm_pkg::t_cmd  cmd;
    dllm_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    dllm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dllm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ sim/list_shadow_compare.sv @@
`timescale 1ns / 1ps

module list_shadow_compare
    import dllm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_req                 i_req,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  t_rsp                 i_rsp,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding,
    output logic [NODES-1:0]     o_linked
);

    logic [PTR_W-1:0] nxt [NODES];
    logic [PTR_W-1:0] prv [NODES];
    logic [PTR_W-1:0] hd [LISTS];
    logic [PTR_W-1:0] tl [LISTS];
    logic [CNT_W-1:0] cnt [LISTS];
    logic [CNT_W-1:0] limit;
    t_rsp             due_results [$];

    function automatic logic [PTR_W-1:0] rd_nxt(logic [PTR_W-1:0] i);
        return (i < PTR_NONE) ? nxt[i[NODE_W-1:0]] : PTR_NONE;
    endfunction

    function automatic logic [PTR_W-1:0] rd_prv(logic [PTR_W-1:0] i);
        return (i < PTR_NONE) ? prv[i[NODE_W-1:0]] : PTR_NONE;
    endfunction

    function automatic void wr_nxt(logic [PTR_W-1:0] i, logic [PTR_W-1:0] v);
        if (i < PTR_NONE) nxt[i[NODE_W-1:0]] = v;
    endfunction

    function automatic void wr_prv(logic [PTR_W-1:0] i, logic [PTR_W-1:0] v);
        if (i < PTR_NONE) prv[i[NODE_W-1:0]] = v;
    endfunction

    function automatic t_rsp apply_list_op(t_req r);
        t_rsp             res;
        logic [LIST_W-1:0] l;
        logic [LIST_W-1:0] s;
        logic [PTR_W-1:0] n;
        logic [PTR_W-1:0] rf;
        logic [PTR_W-1:0] x;
        logic [PTR_W-1:0] pv;
        logic [PTR_W-1:0] nx;
        logic [CNT_W:0]   sum;
        l = r.list_id;
        s = r.src_list;
        n = {1'b0, r.node_id};
        rf = {1'b0, r.ref_node};
        res = '0;
        case (r.op)
            OP_CLEAR: begin
                hd[l] = PTR_NONE;
                tl[l] = PTR_NONE;
                cnt[l] = '0;
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_BEFORE: begin
                if (cnt[l] >= CNT_MAX || (limit != 0 && cnt[l] >= limit)) begin
                    res.status = STS_LIMIT;
                end else begin
                    if (r.op == OP_INS_HEAD) begin
                        x = hd[l];
                        if (x != PTR_NONE) begin
                            wr_nxt(n, x);
                            wr_prv(x, n);
                        end else begin
                            tl[l] = n;
                            wr_nxt(n, PTR_NONE);
                        end
                        hd[l] = n;
                        wr_prv(n, PTR_NONE);
                    end else if (r.op == OP_INS_TAIL) begin
                        x = tl[l];
                        if (x != PTR_NONE) begin
                            wr_prv(n, x);
                            wr_nxt(x, n);
                        end else begin
                            hd[l] = n;
                            wr_prv(n, PTR_NONE);
                        end
                        tl[l] = n;
                        wr_nxt(n, PTR_NONE);
                    end else if (r.op == OP_INS_AFTER) begin
                        x = rd_nxt(rf);
                        wr_nxt(rf, n);
                        wr_prv(n, rf);
                        wr_nxt(n, x);
                        if (x == PTR_NONE) tl[l] = n;
                        else wr_prv(x, n);
                    end else begin
                        x = rd_prv(rf);
                        wr_prv(rf, n);
                        wr_nxt(n, rf);
                        wr_prv(n, x);
                        if (x == PTR_NONE) hd[l] = n;
                        else wr_nxt(x, n);
                    end
                    o_linked[n[NODE_W-1:0]] = 1'b1;
                    cnt[l] = cnt[l] + 1'b1;
                end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
                if (cnt[l] == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    if (r.op == OP_POP_HEAD) begin
                        x = hd[l];
                        nx = rd_nxt(x);
                        if (nx == PTR_NONE) begin
                            hd[l] = PTR_NONE;
                            tl[l] = PTR_NONE;
                        end else begin
                            hd[l] = nx;
                            wr_prv(nx, PTR_NONE);
                        end
                        wr_nxt(x, PTR_NONE);
                    end else begin
                        x = tl[l];
                        pv = rd_prv(x);
                        if (pv == PTR_NONE) begin
                            hd[l] = PTR_NONE;
                            tl[l] = PTR_NONE;
                        end else begin
                            tl[l] = pv;
                            wr_nxt(pv, PTR_NONE);
                        end
                        wr_prv(x, PTR_NONE);
                    end
                    res.popped_node = (x < PTR_NONE) ? x[NODE_W-1:0] : '0;
                    cnt[l] = cnt[l] - 1'b1;
                end
            end
            OP_REMOVE: begin
                if (cnt[l] == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    pv = rd_prv(n);
                    nx = rd_nxt(n);
                    if (pv == PTR_NONE) begin
                        hd[l] = nx;
                        wr_prv(nx, PTR_NONE);
                    end
                    if (nx == PTR_NONE) begin
                        tl[l] = pv;
                        wr_nxt(pv, PTR_NONE);
                    end
                    if (pv != PTR_NONE && nx != PTR_NONE) begin
                        wr_prv(nx, pv);
                        wr_nxt(pv, nx);
                    end
                    wr_prv(n, PTR_NONE);
                    wr_nxt(n, PTR_NONE);
                    cnt[l] = cnt[l] - 1'b1;
                end
            end
            OP_SPLICE_FRONT, OP_SPLICE_BACK: begin
                sum = cnt[l] + cnt[s];
                if (s == l) begin
                end else if (sum > CNT_MAX || (limit != 0 && sum > limit)) begin
                    res.status = STS_LIMIT;
                end else if (cnt[s] != 0) begin
                    if (cnt[l] == 0) begin
                        hd[l] = hd[s];
                        tl[l] = tl[s];
                    end else if (r.op == OP_SPLICE_FRONT) begin
                        wr_prv(hd[l], tl[s]);
                        wr_nxt(tl[s], hd[l]);
                        hd[l] = hd[s];
                    end else begin
                        wr_nxt(tl[l], hd[s]);
                        wr_prv(hd[s], tl[l]);
                        tl[l] = tl[s];
                    end
                    cnt[l] = sum[CNT_W-1:0];
                    hd[s] = PTR_NONE;
                    tl[s] = PTR_NONE;
                    cnt[s] = '0;
                end
            end
            default: begin
            end
        endcase
        res.list_count = cnt[l];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS; i++) begin
                hd[i] = PTR_NONE;
                tl[i] = PTR_NONE;
                cnt[i] = '0;
            end
            limit = '0;
            due_results.delete();
            o_linked = '0;
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) limit = i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected response %p", i_rsp);
                end else begin
                    want = due_results.pop_front();
                    if (want.status != i_rsp.status || want.popped_node != i_rsp.popped_node
                            || want.list_count != i_rsp.list_count) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("response mismatch: expected %p, got %p", want, i_rsp);
                    end
                end
            end
            if (i_req_valid && i_req_ready) due_results.push_back(apply_list_op(i_req));
        end
        o_outstanding = due_results.size();
    end

endmodule

@@ sim/tb_doubly_linked_list_manager.sv @@
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager;
    import dllm_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_req_valid;
    logic             o_req_ready;
    t_req             i_req;
    logic             o_rsp_valid;
    logic             i_rsp_ready;
    t_rsp             o_rsp;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;
    int               mismatches;
    int               outstanding;
    logic [NODES-1:0] linked;

    doubly_linked_list_manager u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    list_shadow_compare u_compare (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .i_req_ready   (o_req_ready),
        .i_req         (i_req),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .i_rsp         (o_rsp),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_linked      (linked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[doubly_linked_list_manager] ERROR");
        $finish;
    end

    // hold off the receiver for a random number of cycles per response
    initial begin
        int k;
        i_rsp_ready <= 1'b0;
        forever begin
            k = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (k > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!o_rsp_valid);
        end
    end

    bit burst;

    task automatic send_request(logic [3:0] op, int l, int n, int rf, int s);
        t_req r;
        int   gap;
        r.op = op;
        r.list_id = l[LIST_W-1:0];
        r.node_id = n[NODE_W-1:0];
        r.ref_node = rf[NODE_W-1:0];
        r.src_list = s[LIST_W-1:0];
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_linked();
        int n;
        do n = $urandom_range(0, NODES - 1); while (!linked[n]);
        return n;
    endfunction

    task automatic random_request();
        int w;
        int n;
        w = $urandom_range(0, 99);
        n = $urandom_range(0, NODES - 1);
        if (w < 20)
            send_request(OP_INS_HEAD, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 40)
            send_request(OP_INS_TAIL, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 48)
            send_request(OP_INS_AFTER, $urandom_range(0, 3), n, pick_linked(), $urandom);
        else if (w < 56)
            send_request(OP_INS_BEFORE, $urandom_range(0, 3), n, pick_linked(), $urandom);
        else if (w < 66)
            send_request(OP_POP_HEAD, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 76)
            send_request(OP_POP_TAIL, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 83)
            send_request(OP_REMOVE, $urandom_range(0, 3), pick_linked(), $urandom, $urandom);
        else if (w < 88)
            send_request(OP_SPLICE_FRONT, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 93)
            send_request(OP_SPLICE_BACK, $urandom_range(0, 3), n, $urandom, $urandom);
        else if (w < 96)
            send_request(OP_CLEAR, $urandom_range(0, 3), n, $urandom, $urandom);
        else
            send_request($urandom_range(10, 15), $urandom_range(0, 3), n, $urandom, $urandom);
    endtask

    task automatic random_phase(int items);
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == items / 2) drain();
            random_request();
        end
    endtask

    initial begin
        burst = 1'b0;
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_POP_HEAD, 2, 0, 0, 0);
        send_request(OP_REMOVE, 3, 0, 0, 0);
        send_request(OP_INS_HEAD, 0, 0, 0, 0);
        send_request(OP_INS_TAIL, 0, 255, 255, 3);
        send_request(OP_INS_AFTER, 0, 5, 0, 0);
        send_request(OP_INS_BEFORE, 0, 7, 255, 0);
        send_request(OP_INS_BEFORE, 0, 9, 0, 0);
        send_request(OP_POP_HEAD, 0, 0, 0, 0);
        send_request(OP_POP_TAIL, 0, 0, 0, 0);
        send_request(OP_REMOVE, 0, 5, 0, 0);
        send_request(OP_INS_TAIL, 1, 10, 0, 0);
        send_request(OP_INS_TAIL, 1, 11, 0, 0);
        send_request(OP_SPLICE_FRONT, 0, 0, 0, 1);
        send_request(OP_SPLICE_BACK, 2, 0, 0, 0);
        send_request(OP_SPLICE_BACK, 2, 0, 0, 2);
        send_request(OP_SPLICE_FRONT, 2, 0, 0, 3);
        send_request(OP_INS_AFTER, 2, 20, 11, 0);
        send_request(4'd10, 3, 170, 85, 2);
        send_request(4'd15, 1, 85, 170, 1);
        send_request(OP_CLEAR, 2, 0, 0, 0);
        send_request(OP_POP_TAIL, 2, 0, 0, 0);

        write_limit(1);
        send_request(OP_INS_HEAD, 1, 30, 0, 0);
        send_request(OP_INS_HEAD, 1, 31, 0, 0);
        send_request(OP_INS_TAIL, 3, 32, 0, 0);
        send_request(OP_SPLICE_BACK, 1, 0, 0, 3);
        random_phase(60);

        write_limit(256);
        random_phase(90);
        write_limit(3);
        random_phase(80);
        write_limit($urandom_range(2, 12));
        random_phase(80);

        // fill one list up to the count ceiling
        write_limit(0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        send_request(OP_CLEAR, 1, 0, 0, 0);
        burst = 1'b1;
        for (int i = 0; i < 511; i++)
            send_request(OP_INS_TAIL, 0, $urandom_range(0, NODES - 1), 0, 0);
        burst = 1'b0;
        send_request(OP_INS_HEAD, 0, 1, 0, 0);
        send_request(OP_INS_TAIL, 1, 2, 0, 0);
        send_request(OP_SPLICE_BACK, 0, 0, 0, 1);
        send_request(OP_POP_HEAD, 0, 0, 0, 0);
        send_request(OP_POP_TAIL, 0, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        random_phase(60);

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[doubly_linked_list_manager] OK");
        end else begin
            $display("[doubly_linked_list_manager] ERROR");
        end
        $finish;
    end

endmodule
